FILE: design/swm_pkg.sv
package swm_pkg;

	// Default sizes of the block.
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// The window size register.
	localparam int         CFG_W     = 7;
	localparam logic [6:0] CFG_RESET = 7'd1;

	// Per-cycle control that is broadcast to every cell of the chain.
	typedef struct packed {
		logic shift;   // An input transfer happens in this cycle.
		logic restart; // The transferred sample opens a new stream.
	} swm_cell_ctrl_t;

endpackage

FILE: design/swm_cell.sv
module swm_cell
	import swm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  swm_cell_ctrl_t                ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] prev_max,
	output logic signed [SAMPLE_BITS-1:0] next_max,
	output logic signed [SAMPLE_BITS-1:0] max_q
);

	// Cell k holds the maximum of the last k+1 samples. The new value is the
	// maximum that the neighbor toward the newer samples held, merged with the
	// incoming sample. A new stream drops everything older than the sample.
	always_comb begin
		if (ctrl.restart || (sample > prev_max)) begin
			next_max = sample;
		end else begin
			next_max = prev_max;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			max_q <= next_max;
		end
	end

endmodule

FILE: design/sliding_window_maximum.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     sample, stream_start, stream_end
// out       output     out_valid / out_stall   window_max, final_result
// config    input      window_size_wr_en       window_size_wr_data
//
// One sample is taken per clock while in_stall is low; its result, if any,
// appears in the next cycle. The rate is set by the chain of cells, each of
// which merges the new sample with its neighbor's maximum in the same cycle.
// Reset clears the fill count, the output valid and sets the window size to 1.
// The input is stalled only while a result is waiting and the output is stalled.
module sliding_window_maximum
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          stream_start,
	input  logic                          stream_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic                          final_result,
	input  logic                          window_size_wr_en,
	input  logic [CFG_W-1:0]              window_size_wr_data
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [CFG_W-1:0]              window_size_q;
	logic [CNT_W-1:0]              eff_window;
	logic [CNT_W-1:0]              filled_q;
	logic [CNT_W-1:0]              filled_clr;
	logic [CNT_W-1:0]              filled_clamp;
	logic [CNT_W-1:0]              filled_next;
	logic [IDX_W-1:0]              tap_idx;
	logic                          in_xfer;
	logic                          emit;
	swm_cell_ctrl_t                cell_ctrl;
	logic signed [SAMPLE_BITS-1:0] cell_prev [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] cell_next [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] cell_max  [WINDOW_MAX];
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] window_max_q;
	logic                          final_result_q;

	// Window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_RESET;
		end else if (window_size_wr_en) begin
			window_size_q <= window_size_wr_data;
		end
	end

	// A zero window acts as one, a window above the chain length as the full chain.
	always_comb begin
		if (window_size_q == '0) begin
			eff_window = CNT_W'(1);
		end else if (32'(window_size_q) > 32'(WINDOW_MAX)) begin
			eff_window = CNT_W'(WINDOW_MAX);
		end else begin
			eff_window = CNT_W'(window_size_q);
		end
	end

	assign tap_idx = IDX_W'(eff_window - CNT_W'(1));

	// Handshake: a waiting result that is not taken holds the input back.
	assign in_stall  = out_valid_q && out_stall;
	assign in_xfer   = in_valid && !in_stall;

	assign cell_ctrl.shift   = in_xfer;
	assign cell_ctrl.restart = stream_start;

	// The chain of cells. The first cell sees only the new sample.
	genvar k;
	generate
		for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign cell_prev[k] = sample;
			end else begin : g_body
				assign cell_prev[k] = cell_max[k-1];
			end
			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk     (clk),
				.ctrl    (cell_ctrl),
				.sample  (sample),
				.prev_max(cell_prev[k]),
				.next_max(cell_next[k]),
				.max_q   (cell_max[k])
			);
		end
	endgenerate

	// Fill count: cleared by a new stream, clamped to the window, then counted up.
	always_comb begin
		filled_clr   = stream_start ? '0 : filled_q;
		filled_clamp = (filled_clr > eff_window) ? eff_window : filled_clr;
		filled_next  = (filled_clamp < eff_window) ? filled_clamp + CNT_W'(1)
		                                           : filled_clamp;
		emit         = (filled_next == eff_window);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (in_xfer) begin
			filled_q <= filled_next;
		end
	end

	// Output register: loaded from the cell that covers the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && emit) begin
			window_max_q   <= cell_next[tap_idx];
			final_result_q <= stream_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign window_max   = window_max_q;
	assign final_result = final_result_q;

	// A new stream leaves exactly one sample counted.
	a_start_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && stream_start |=> filled_q == CNT_W'(1))
		else $error("fill count wrong after stream start");

	// The fill count never exceeds the chain length.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(filled_q) <= 32'(WINDOW_MAX))
		else $error("fill count beyond chain length");

	// With a window of one, each sample comes straight back as its own maximum.
	a_unit_window: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && eff_window == CNT_W'(1) |=> out_valid && window_max == $past(sample))
		else $error("unit window result mismatch");

endmodule
